>>> rtl/rgb_3x3_sharpen_edge_filter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB 3x3 sharpen / edge filter
// Shared concurrent-assertion forms, each clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_SHARPEN_EDGE_FILTER_DEFINES_SVH
`define RGB_3X3_SHARPEN_EDGE_FILTER_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define RSEF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// When the trigger holds, the consequence holds in the following cycle.
`define RSEF_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rsef_pkg.sv
// ----------------------------------------------------------------------------
// rsef_pkg
// Types and constants shared by the RGB 3x3 sharpen / edge filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsef_pkg;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int TAPS  = 9;
  localparam int CENTRE = 4;

  // Configuration port.
  localparam int CFG_IDX_W    = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST    = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic MODE_SHARPEN = 1'b0;
  localparam logic MODE_EDGE    = 1'b1;

  localparam logic [3:0] SHARPEN_WEIGHT = 4'd10;
  localparam logic [3:0] EDGE_WEIGHT    = 4'd9;
  localparam logic [CH_W-1:0] CH_MAX    = 8'd255;

  // Output queue.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] window_t;
  typedef logic [TAPS-1:0][CH_W-1:0] chan_win_t;

  // One pixel moving into the line stores and the window.
  typedef struct packed {
    logic   valid;
    pixel_t px;
  } push_t;

  // One result beat waiting in the output queue.
  typedef struct packed {
    pixel_t px;
    logic   last;
  } beat_t;

endpackage

`default_nettype wire

>>> rtl/rgb_3x3_sharpen_edge_filter.sv
// ----------------------------------------------------------------------------
// rgb_3x3_sharpen_edge_filter
// Streaming 3x3 sharpen or edge filter on RGB pixels in raster order. The
// block takes one beat per clock, pixel or drain, and keeps that rate as long
// as the result side takes one beat per clock; a result leaves after the
// input beat that completes its window, held by the registered line-store
// read, the window register and the result register. Results run width+1
// pixels behind the input, so after the last pixel of a frame the user sends
// width+1 drain beats to flush the tail; the beat carrying the last pixel of
// the frame raises frame_end. Border pixels pass through in sharpen mode and
// come out as zero in edge mode. The line stores come up with no defined
// contents and need no clearing after reset: only border windows ever see
// unwritten entries. Configuration is written only while no pixel is
// pending; this binds the user, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_3x3_sharpen_edge_filter_defines.svh"

module rgb_3x3_sharpen_edge_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration write port.
  input  wire                                cfg_we_i,
  input  wire  [rsef_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [rsef_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Input channel.
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                func_i,
  input  wire  [rsef_pkg::CH_W-1:0]          red_in_i,
  input  wire  [rsef_pkg::CH_W-1:0]          green_in_i,
  input  wire  [rsef_pkg::CH_W-1:0]          blue_in_i,
  // Output channel.
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [rsef_pkg::CH_W-1:0]          red_out_o,
  output logic [rsef_pkg::CH_W-1:0]          green_out_o,
  output logic [rsef_pkg::CH_W-1:0]          blue_out_o,
  output logic                               frame_end_o
);

  // Line-store address width, and a column width that holds MAX_WIDTH, the
  // widest register value and width+1.
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > rsef_pkg::WIDTH_REG_W) ? AW + 1 : rsef_pkg::WIDTH_REG_W;
  localparam int RW = rsef_pkg::HEIGHT_REG_W;
  localparam int QAW = rsef_pkg::OQ_AW;
  localparam int QCW = rsef_pkg::OQ_CW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rsef_pkg::WIDTH_REG_W-1:0] width_q;
  logic [RW-1:0]                    height_q;
  logic                             mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rsef_pkg::WIDTH_RST;
      height_q <= rsef_pkg::HEIGHT_RST;
      mode_q   <= rsef_pkg::MODE_SHARPEN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsef_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i[rsef_pkg::WIDTH_REG_W-1:0];
        rsef_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[RW-1:0];
        rsef_pkg::REG_MODE:   mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The effective frame size: a zero width or height counts as one, and
  // the width is capped at what the line stores hold, the height at HEIGHT_LIMIT.
  logic [CW-1:0] w_eff;
  logic [CW-1:0] w_m1;
  logic [CW-1:0] w_p1;
  logic [RW-1:0] h_eff;
  logic [RW-1:0] h_m1;

  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (CW'(width_q) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (height_q > rsef_pkg::HEIGHT_LIMIT) begin
      h_eff = rsef_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = height_q;
    end
  end

  assign w_m1 = w_eff - CW'(1);
  assign w_p1 = w_eff + CW'(1);
  assign h_m1 = h_eff - RW'(1);

  // --------------------------------------------------------------------------
  // Accept stage: position tracking for the incoming and outgoing pixels
  // --------------------------------------------------------------------------
  // The input side counts column and row of the next pixel; lead counts
  // pixels moved in, up to width+1, after which every pixel moved in
  // releases the result for the pixel width+1 places earlier. The output
  // side tracks that pixel's column and row to find the border and the
  // frame end.
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] lead_q, lead_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;

  logic             accept;
  logic             in_full;
  logic             advance;
  logic             emit;
  logic             last;
  logic             border;
  rsef_pkg::pixel_t in_px;
  logic             pop;

  assign accept  = in_valid_i && !in_stall_o;
  // Once every pixel of the frame is in, any beat moves a zero pixel in;
  // before that a drain beat has no effect.
  assign in_full = in_row_q >= h_eff;
  assign advance = accept && (in_full || (func_i == rsef_pkg::FUNC_PIXEL));
  assign emit    = advance && (lead_q == w_p1);
  assign last    = (out_row_q == h_m1) && (out_col_q == w_m1);
  assign border  = (out_row_q == '0) || (out_row_q == h_m1) ||
                   (out_col_q == '0) || (out_col_q == w_m1);
  assign in_px   = in_full ? '0 : {red_in_i, green_in_i, blue_in_i};

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    lead_d    = lead_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (advance) begin
      if (in_col_q == w_m1) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (lead_q != w_p1) begin
        lead_d = lead_q + CW'(1);
      end
    end
    if (emit) begin
      if (last) begin
        // The frame is complete; the next pixel starts a new one.
        in_col_d  = '0;
        in_row_d  = '0;
        lead_d    = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (out_col_q == w_m1) begin
        out_col_d = '0;
        out_row_d = out_row_q + RW'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  // Flags that follow the pixel through the window stage to the lanes.
  rsef_pkg::push_t s1_push_q;
  logic [AW-1:0]   s1_addr_q;
  logic            s1_emit_q;
  logic            s1_border_q;
  logic            s1_last_q;
  logic            s2_emit_q;
  logic            s2_border_q;
  logic            s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q        <= '0;
      in_row_q        <= '0;
      lead_q          <= '0;
      out_col_q       <= '0;
      out_row_q       <= '0;
      s1_push_q       <= '0;
      s1_emit_q       <= 1'b0;
      s2_emit_q       <= 1'b0;
    end else begin
      in_col_q        <= in_col_d;
      in_row_q        <= in_row_d;
      lead_q          <= lead_d;
      out_col_q       <= out_col_d;
      out_row_q       <= out_row_d;
      s1_push_q.valid <= advance;
      s1_push_q.px    <= in_px;
      s1_emit_q       <= emit;
      s2_emit_q       <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q    <= in_col_q[AW-1:0];
    s1_border_q  <= border;
    s1_last_q    <= last;
    s2_border_q  <= s1_border_q;
    s2_last_q    <= s1_last_q;
  end

  // --------------------------------------------------------------------------
  // Line stores and window
  // --------------------------------------------------------------------------
  // The stores are read at the column of the next pixel on every clock, so
  // the entries of a pixel accepted on one edge are ready on the next, when
  // the window shifts and the stores are written back.
  rsef_pkg::window_t win;

  rsef_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (in_col_q[AW-1:0]),
    .wr_addr_i (s1_addr_q),
    .push_i    (s1_push_q),
    .win_o     (win)
  );

  // --------------------------------------------------------------------------
  // Channel lanes and merge
  // --------------------------------------------------------------------------
  // Three copies of the kernel work on the red, green and blue bytes of the
  // window side by side; the merge picks the border value or the filtered
  // value and forms the result beat.
  logic [rsef_pkg::PIX_W-1:0] lane_px;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rsef_pkg::chan_win_t taps;

    always_comb begin
      for (int i = 0; i < rsef_pkg::TAPS; i++) begin
        taps[i] = win[i][ch*rsef_pkg::CH_W +: rsef_pkg::CH_W];
      end
    end

    rsef_lane u_lane (
      .taps_i (taps),
      .mode_i (mode_q),
      .res_o  (lane_px[ch*rsef_pkg::CH_W +: rsef_pkg::CH_W])
    );
  end

  rsef_pkg::beat_t beat;

  always_comb begin
    beat.last = s2_last_q;
    if (!s2_border_q) begin
      beat.px = lane_px;
    end else if (mode_q == rsef_pkg::MODE_SHARPEN) begin
      beat.px = win[rsef_pkg::CENTRE];
    end else begin
      beat.px = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  // A result slot is reserved when the beat that produces it is accepted and
  // freed when the result leaves, so the input stalls only when every slot
  // is taken and never waits on the output stall in the same cycle.
  rsef_pkg::beat_t oq_q [rsef_pkg::OQ_DEPTH];
  logic [QAW-1:0]  oq_wr_q;
  logic [QAW-1:0]  oq_rd_q;
  logic [QCW-1:0]  oq_cnt_q, oq_cnt_d;
  logic [QCW-1:0]  used_q, used_d;

  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (s2_emit_q && !pop) begin
      oq_cnt_d = oq_cnt_q + QCW'(1);
    end else if (!s2_emit_q && pop) begin
      oq_cnt_d = oq_cnt_q - QCW'(1);
    end
    used_d = used_q;
    if (emit && !pop) begin
      used_d = used_q + QCW'(1);
    end else if (!emit && pop) begin
      used_d = used_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
      used_q   <= '0;
    end else begin
      if (s2_emit_q) begin
        oq_wr_q <= oq_wr_q + QAW'(1);
      end
      if (pop) begin
        oq_rd_q <= oq_rd_q + QAW'(1);
      end
      oq_cnt_q <= oq_cnt_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_emit_q) begin
      oq_q[oq_wr_q] <= beat;
    end
  end

  assign in_stall_o  = used_q == QCW'(rsef_pkg::OQ_DEPTH);
  assign out_valid_o = oq_cnt_q != '0;
  assign red_out_o   = oq_q[oq_rd_q].px[3*rsef_pkg::CH_W-1:2*rsef_pkg::CH_W];
  assign green_out_o = oq_q[oq_rd_q].px[2*rsef_pkg::CH_W-1:rsef_pkg::CH_W];
  assign blue_out_o  = oq_q[oq_rd_q].px[rsef_pkg::CH_W-1:0];
  assign frame_end_o = oq_q[oq_rd_q].last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RSEF_ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= QCW'(rsef_pkg::OQ_DEPTH),
                      "result slots overbooked")
  `RSEF_ASSERT_ALWAYS(a_queue_reserved, clk_i, rst_ni, oq_cnt_q <= used_q,
                      "queued result without a reserved slot")
  `RSEF_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, emit && last,
                    (in_row_q == '0) && (lead_q == '0) &&
                    (out_row_q == '0) && (out_col_q == '0),
                    "counters not cleared after frame end")

endmodule

`default_nettype wire

>>> rtl/rsef_ram.sv
// ----------------------------------------------------------------------------
// rsef_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsef_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire  [WIDTH-1:0]             wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/rsef_window.sv
// ----------------------------------------------------------------------------
// rsef_window
// Two line stores and the 3x3 window that slides one column per pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsef_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  [$clog2(MAX_WIDTH)-1:0]     rd_addr_i,
  input  wire  [$clog2(MAX_WIDTH)-1:0]     wr_addr_i,
  input  wire  rsef_pkg::push_t            push_i,
  output rsef_pkg::window_t                win_o
);

  rsef_pkg::pixel_t  up_rdata;
  rsef_pkg::pixel_t  mid_rdata;
  rsef_pkg::pixel_t  up_rd;
  rsef_pkg::pixel_t  mid_rd;
  rsef_pkg::pixel_t  fwd_up_q;
  rsef_pkg::pixel_t  fwd_mid_q;
  logic              fwd_q;
  logic              fwd_d;
  rsef_pkg::window_t win_q;
  rsef_pkg::window_t win_d;

  // Both stores are addressed by the column; the upper one takes what the
  // middle one held, so it runs two rows behind the incoming pixel.
  rsef_ram #(
    .WIDTH (rsef_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (push_i.valid),
    .waddr_i (wr_addr_i),
    .wdata_i (mid_rd),
    .raddr_i (rd_addr_i),
    .rdata_o (up_rdata)
  );

  rsef_ram #(
    .WIDTH (rsef_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (push_i.valid),
    .waddr_i (wr_addr_i),
    .wdata_i (push_i.px),
    .raddr_i (rd_addr_i),
    .rdata_o (mid_rdata)
  );

  // A one-pixel-wide frame reads the column it writes in the same cycle;
  // the written values are forwarded in place of the stale read.
  assign fwd_d  = push_i.valid && (wr_addr_i == rd_addr_i);
  assign up_rd  = fwd_q ? fwd_up_q  : up_rdata;
  assign mid_rd = fwd_q ? fwd_mid_q : mid_rdata;

  always_comb begin
    win_d = win_q;
    if (push_i.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]     = win_q[r*3 + 1];
        win_d[r*3 + 1] = win_q[r*3 + 2];
      end
      win_d[2] = up_rd;
      win_d[5] = mid_rd;
      win_d[8] = push_i.px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      win_q <= '0;
    end else begin
      fwd_q <= fwd_d;
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_up_q  <= mid_rd;
    fwd_mid_q <= push_i.px;
  end

  assign win_o = win_q;

endmodule

`default_nettype wire

>>> rtl/rsef_lane.sv
// ----------------------------------------------------------------------------
// rsef_lane
// One color channel of the 3x3 sharpen or Laplacian edge kernel, clamped to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsef_lane (
  input  wire  rsef_pkg::chan_win_t   taps_i,
  input  wire                         mode_i,
  output logic [rsef_pkg::CH_W-1:0]   res_o
);

  logic [9:0]         row_sum [3];
  logic [11:0]        sum;
  logic [3:0]         weight;
  logic [11:0]        prod;
  logic signed [12:0] diff;

  // Row sums first, then the three rows together.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = 10'(taps_i[r*3]) + 10'(taps_i[r*3 + 1]) + 10'(taps_i[r*3 + 2]);
    end
    sum = 12'(row_sum[0]) + 12'(row_sum[1]) + 12'(row_sum[2]);
  end

  // Sharpen uses ten times the center, edge nine times, each minus the 3x3 sum.
  assign weight = (mode_i == rsef_pkg::MODE_EDGE) ? rsef_pkg::EDGE_WEIGHT
                                                  : rsef_pkg::SHARPEN_WEIGHT;
  assign prod   = 12'(taps_i[rsef_pkg::CENTRE]) * 12'(weight);
  assign diff   = $signed({1'b0, prod}) - $signed({1'b0, sum});

  always_comb begin
    if (diff < 13'sd0) begin
      res_o = '0;
    end else if (diff > $signed({5'd0, rsef_pkg::CH_MAX})) begin
      res_o = rsef_pkg::CH_MAX;
    end else begin
      res_o = diff[rsef_pkg::CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_rgb_3x3_sharpen_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_3x3_sharpen_edge_filter
// Self-checking bench for the streaming 3x3 sharpen / edge filter. Whole
// frames of RGB pixels are pushed in raster order, each followed by the
// width+1 beats that flush its tail. A scoreboard class keeps its own
// line stores, window and frame counters, predicts every filtered pixel, and
// checks each result beat in order. Both sides of the block idle and stall at
// random, and the frame geometry and mode are changed between frames.
// ----------------------------------------------------------------------------
module tb_rgb_3x3_sharpen_edge_filter;

  localparam int CH_W       = rsef_pkg::CH_W;
  localparam int TAPS       = rsef_pkg::TAPS;
  localparam int CENTRE     = rsef_pkg::CENTRE;
  localparam int CFG_IDX_W  = rsef_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rsef_pkg::CFG_DATA_W;

  localparam int LINE_MAX      = 1024;  // matches the block's default MAX_WIDTH
  localparam int SETTLE_CYCLES = 8;     // covers the registered result path
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STUCK_LIMIT   = 4000;  // cycles with no beat moving on either side
  localparam int REPORT_LIMIT  = 10;

  // Directed frame content: one bright-red, dark-green center on a bright-green rim.
  // Red clamps high, green clamps low and blue stays inside the range.
  localparam rsef_pkg::pixel_t PEAK_PX = {8'd255, 8'd0, 8'd128};
  localparam rsef_pkg::pixel_t RIM_PX  = {8'd0, 8'd255, 8'd120};

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } filtered_pixel_t;

  // How the pixels of a random frame are drawn.
  typedef enum int {
    STYLE_DIRECTED,
    STYLE_NOISE,   // every channel uniform over 0..255
    STYLE_FLAT,    // small ripples on a flat level; sums can still clamp
    STYLE_RAILS    // only 0 and 255, so sums clamp both ways
  } texture_e;

  // --------------------------------------------------------------------------
  // Scoreboard: a cycle-free model of the filter plus the queue of filtered
  // pixels that the block still owes.
  // --------------------------------------------------------------------------
  class filtered_pixel_board;
    int unsigned      reg_width;
    int unsigned      reg_height;
    logic             reg_mode;
    rsef_pkg::pixel_t row_above[LINE_MAX];
    rsef_pkg::pixel_t row_middle[LINE_MAX];
    rsef_pkg::pixel_t win[TAPS];
    int unsigned      in_count;
    int unsigned      out_count;
    int unsigned      checked;
    int unsigned      mismatches;
    filtered_pixel_t  expected[$];

    function new();
      reg_width  = int'(rsef_pkg::WIDTH_RST);
      reg_height = int'(rsef_pkg::HEIGHT_RST);
      reg_mode   = rsef_pkg::MODE_SHARPEN;
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_middle[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_count   = 0;
      out_count  = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value);
      case (idx)
        rsef_pkg::REG_WIDTH:  reg_width  = int'(value[rsef_pkg::WIDTH_REG_W-1:0]);
        rsef_pkg::REG_HEIGHT: reg_height = int'(value[rsef_pkg::HEIGHT_REG_W-1:0]);
        rsef_pkg::REG_MODE:   reg_mode   = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned row_len();
      if (reg_width == 0) return 1;
      if (reg_width > LINE_MAX) return LINE_MAX;
      return reg_width;
    endfunction

    function int unsigned row_count();
      if (reg_height == 0) return 1;
      if (reg_height > int'(rsef_pkg::HEIGHT_LIMIT)) return int'(rsef_pkg::HEIGHT_LIMIT);
      return reg_height;
    endfunction

    // Weighted center minus the 3x3 sum on one channel, clamped to 0..255.
    function logic [CH_W-1:0] channel_out(input int lsb, input int centre_weight);
      int acc;
      acc = 0;
      for (int k = 0; k < TAPS; k++) acc += int'(win[k][lsb +: CH_W]);
      acc = centre_weight * int'(win[CENTRE][lsb +: CH_W]) - acc;
      if (acc > int'(rsef_pkg::CH_MAX)) acc = int'(rsef_pkg::CH_MAX);
      if (acc < 0) acc = 0;
      return acc[CH_W-1:0];
    endfunction

    // Called for every accepted input beat.
    function void note_beat(input logic func, input rsef_pkg::pixel_t px_in);
      int unsigned      w;
      int unsigned      h;
      int unsigned      total;
      int unsigned      n;
      int unsigned      row;
      int unsigned      col;
      int               weight;
      rsef_pkg::pixel_t px;
      filtered_pixel_t  res;
      w     = row_len();
      h     = row_count();
      total = w * h;
      if (out_count >= total) begin
        in_count  = 0;
        out_count = 0;
      end
      n = in_count;
      if (n < total) begin
        // A drain while the frame still lacks pixels does nothing.
        if (func == rsef_pkg::FUNC_DRAIN) return;
        px = px_in;
      end else begin
        // Past the last pixel every beat flushes, whatever it carries.
        px = '0;
      end
      col = n % w;
      for (int r = 0; r < 3; r++) begin
        win[3*r]   = win[3*r+1];
        win[3*r+1] = win[3*r+2];
      end
      win[2] = row_above[col];
      win[5] = row_middle[col];
      win[8] = px;
      row_above[col]  = row_middle[col];
      row_middle[col] = px;
      in_count++;
      if (n < out_count + w + 1) return;

      row = out_count / w;
      col = out_count % w;
      if (row == 0 || row == h - 1 || col == 0 || col == w - 1) begin
        if (reg_mode == rsef_pkg::MODE_SHARPEN) {res.red, res.green, res.blue} = win[CENTRE];
        else {res.red, res.green, res.blue} = '0;
      end else begin
        weight = (reg_mode == rsef_pkg::MODE_SHARPEN) ? int'(rsef_pkg::SHARPEN_WEIGHT)
                                                      : int'(rsef_pkg::EDGE_WEIGHT);
        res.red   = channel_out(2 * CH_W, weight);
        res.green = channel_out(CH_W, weight);
        res.blue  = channel_out(0, weight);
      end
      out_count++;
      res.frame_end = (out_count >= total);
      if (res.frame_end) begin
        in_count  = 0;
        out_count = 0;
      end
      expected.push_back(res);
    endfunction

    // Called for every accepted result beat.
    function void check_beat(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                             input logic [CH_W-1:0] blue, input logic frame_end);
      filtered_pixel_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result beat with nothing pending: rgb=%0d/%0d/%0d end=%0b",
                   red, green, blue, frame_end);
        return;
      end
      want = expected.pop_front();
      if (red !== want.red || green !== want.green || blue !== want.blue ||
          frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result %0d: expected rgb=%0d/%0d/%0d end=%0b, got %0d/%0d/%0d end=%0b",
                   checked, want.red, want.green, want.blue, want.frame_end,
                   red, green, blue, frame_end);
      end
      checked++;
    endfunction

    function void finish_check();
      if (expected.size() != 0) begin
        $display("ERROR: %0d filtered pixels never came out", expected.size());
        mismatches += expected.size();
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = rsef_pkg::REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  func_i      = rsef_pkg::FUNC_PIXEL;
  logic [CH_W-1:0]       red_in_i    = '0;
  logic [CH_W-1:0]       green_in_i  = '0;
  logic [CH_W-1:0]       blue_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CH_W-1:0]       red_out_o;
  logic [CH_W-1:0]       green_out_o;
  logic [CH_W-1:0]       blue_out_o;
  logic                  frame_end_o;

  filtered_pixel_board board = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned beats_sent    = 0;   // pixel and flush beats of random frames
  bit          hold_req      = 1'b0;

  always #4 clk_i = ~clk_i;

  rgb_3x3_sharpen_edge_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  // --------------------------------------------------------------------------
  // Result side. The stall changes on the falling edge. When the stimulus
  // asks for a hold-off, the stall stays high for a long stretch counted
  // here, while the sender keeps offering beats and the block backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every result beat is checked on the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_beat(red_out_o, green_out_o, blue_out_o, frame_end_o);
  end

  // The run is declared hung once no beat has moved on either side for a
  // long time; the longest correct quiet stretch is the receiver hold-off.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no beat moved for %0d cycles", STUCK_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side. Each task starts and ends on a falling edge. Valid is raised
  // for a beat without being lowered first in the same step, and the payload
  // holds while the block stalls.
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic func, input rsef_pkg::pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    {red_in_i, green_in_i, blue_in_i} <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_beat(func, px);
    @(negedge clk_i);
  endtask

  // Stops offering beats and waits until every expected pixel has come out.
  task automatic go_quiet();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.expected.size() != 0);
  endtask

  // Registers are only written with the block empty. Flush beats that make
  // no result may still be in flight when the last result leaves, so a
  // settling wait comes first.
  task automatic write_config(input logic [CFG_DATA_W-1:0] width,
                              input logic [CFG_DATA_W-1:0] height, input logic mode);
    go_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rsef_pkg::REG_WIDTH;
    cfg_wdata_i <= width;
    board.write_reg(rsef_pkg::REG_WIDTH, width);
    @(negedge clk_i);
    cfg_idx_i   <= rsef_pkg::REG_HEIGHT;
    cfg_wdata_i <= height;
    board.write_reg(rsef_pkg::REG_HEIGHT, height);
    @(negedge clk_i);
    cfg_idx_i   <= rsef_pkg::REG_MODE;
    cfg_wdata_i <= {{(CFG_DATA_W-1){1'b0}}, mode};
    board.write_reg(rsef_pkg::REG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] texel(input texture_e tex, input logic [CH_W-1:0] level);
    case (tex)
      STYLE_FLAT:  return level + CH_W'($urandom_range(7));
      STYLE_RAILS: return $urandom_range(1) ? rsef_pkg::CH_MAX : '0;
      default:     return CH_W'($urandom_range(255));
    endcase
  endfunction

  // One whole frame at the current geometry: the pixels, with stray drains
  // mixed in that the block must ignore, then the width+1 flush beats. Some
  // flush beats carry a pixel, which the block treats as a drain. A few
  // drains after the frame find nothing pending and are ignored too.
  task automatic run_frame(input texture_e tex, input bit may_pause);
    int unsigned      w;
    int unsigned      total;
    int unsigned      pause_at;
    rsef_pkg::pixel_t level;
    rsef_pkg::pixel_t px;
    w        = board.row_len();
    total    = w * board.row_count();
    pause_at = (may_pause && $urandom_range(3) == 0) ? $urandom_range(total - 1) : total;
    level    = {CH_W'($urandom_range(248)), CH_W'($urandom_range(248)),
                CH_W'($urandom_range(248))};
    for (int unsigned i = 0; i < total; i++) begin
      // Now and then the sender waits for the block to empty mid-frame.
      if (i == pause_at) go_quiet();
      if ((tex == STYLE_DIRECTED) ? (i == 4) : ($urandom_range(19) == 0))
        push_beat(rsef_pkg::FUNC_DRAIN, rsef_pkg::pixel_t'($urandom));
      if (tex == STYLE_DIRECTED)
        px = (i == w + 1) ? PEAK_PX : RIM_PX;
      else
        px = {texel(tex, level[2*CH_W +: CH_W]), texel(tex, level[CH_W +: CH_W]),
              texel(tex, level[0 +: CH_W])};
      push_beat(rsef_pkg::FUNC_PIXEL, px);
      beats_sent++;
    end
    for (int unsigned i = 0; i <= w; i++) begin
      push_beat(($urandom_range(3) == 0) ? rsef_pkg::FUNC_PIXEL : rsef_pkg::FUNC_DRAIN,
                rsef_pkg::pixel_t'($urandom));
      beats_sent++;
    end
    repeat ($urandom_range(2)) push_beat(rsef_pkg::FUNC_DRAIN, rsef_pkg::pixel_t'($urandom));
  endtask

  // Small frames of random geometry and mode. Width and height zero show up
  // now and then, and some frames follow the last with no register write.
  task automatic random_frames(input int unsigned target);
    texture_e tex;
    while (beats_sent < target) begin
      if ($urandom_range(9) < 6)
        write_config(CFG_DATA_W'(($urandom_range(19) == 0) ? 0 : $urandom_range(12, 1)),
                     CFG_DATA_W'(($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1)),
                     1'($urandom_range(1)));
      tex = texture_e'($urandom_range(STYLE_RAILS, STYLE_NOISE));
      run_frame(tex, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a 3x3 sharpen frame whose one interior pixel clamps red high
    // and green low, then a single-pixel frame in edge mode, which is all
    // border and must come out as zero.
    write_config(3, 3, rsef_pkg::MODE_SHARPEN);
    run_frame(STYLE_DIRECTED, 1'b0);
    write_config(1, 1, rsef_pkg::MODE_EDGE);
    run_frame(STYLE_DIRECTED, 1'b0);

    // Sender idles a little, receiver a lot.
    beats_sent    = 0;
    send_idle_pct = 36;
    recv_idle_pct = 78;
    random_frames(420);

    // Sender idles a lot, receiver a little. During one frame the receiver
    // holds off long enough for the input to back up.
    send_idle_pct = 78;
    recv_idle_pct = 36;
    random_frames(840);
    write_config(12, 8, rsef_pkg::MODE_SHARPEN);
    hold_req = 1'b1;
    run_frame(STYLE_NOISE, 1'b1);

    // No idling at all. Then width zero meaning one column, and height zero
    // meaning one row in edge mode.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(1250);
    write_config(0, 6, rsef_pkg::MODE_SHARPEN);
    run_frame(STYLE_NOISE, 1'b1);
    write_config(5, 0, rsef_pkg::MODE_EDGE);
    run_frame(STYLE_FLAT, 1'b0);

    go_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    board.finish_check();
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
